/* rtl/rau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Input/output word structs, action codes, status codes, sequencer states,
// divider control and status structs.
package rau_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // action codes
  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_NEG = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
  } rau_out_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_FORM,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN,
    S_OUT
  } rau_state_t;

  // shared divider control
  typedef struct packed {
    logic start;
  } rau_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rau_div_sts_t;

endpackage

/* rtl/rau_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div: shared restoring divider
// Unsigned W-bit by W-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div
  import rau_pkg::*;
#(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  rau_div_ctl_t ctl,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output rau_div_sts_t sts,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  rm_r, rm_nxt;
  logic [W-1:0]  dv_r, dv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // one shift-subtract step
  always_comb begin
    trial    = {rm_r, q_r[W-1]};
    diff     = trial - {1'b0, dv_r};
    q_nxt    = q_r;
    rm_nxt   = rm_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      q_nxt    = dividend;
      rm_nxt   = '0;
      dv_nxt   = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rm_nxt = diff[W-1:0];
        q_nxt  = {q_r[W-2:0], 1'b1};
      end else begin
        rm_nxt = trial[W-1:0];
        q_nxt  = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r  <= q_nxt;
    rm_r <= rm_nxt;
    dv_r <= dv_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = q_r;
  assign remainder = rm_r;

`ifndef SYNTH
  // a finished division never overlaps a running one
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  // done follows the last step
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r)) else $error("divider done without run");
  // a start while busy would corrupt the running division
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !ctl.start) else $error("divider restarted while busy");
`endif

endmodule

/* rtl/rational_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add/sub/mul/div/negate with reduction
// Exact 64-bit sign-magnitude intermediates, gcd by Euclid on a shared
// divider, exact division by the gcd, overflow and compare flags.
// ----------------------------------------------------------------------------
//  channel | ports                   | direction | word
//  input   | in_valid/in_ready/in_data   | in    | rau_in_t
//  result  | out_valid/out_ready/out_data| out   | rau_out_t
//
//  One word at a time. The four cross products share one 32x32 multiplier;
//  each Euclid step and each of the two final divisions runs on the shared
//  restoring divider (start, 64 steps, done), so the time a word takes
//  grows with its number of gcd steps and is data dependent.
//  Synchronous active-low reset returns the sequencer to idle.
//  A result waiting on out_ready holds the unit; in_ready is low meanwhile.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rau_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rau_out_t out_data
);

  localparam int unsigned DW = 64;
  localparam logic [DW-1:0] LIM = DW'(1) << (VALUE_WIDTH - 1);

  rau_state_t state_r, state_nxt;

  // operand magnitudes and signs
  logic [31:0] an_r, ad_r, bn_r, bd_r;
  logic        ans_r, ads_r, bns_r, bds_r;
  logic [2:0]  act_r;
  logic [1:0]  mi_r;                 // multiply step
  logic [DW-1:0] p0_r, p1_r, p2_r, p3_r; // an*bd, bn*ad, an*bn, ad*bd
  logic [DW-1:0] nm_r, dm_r;          // unreduced result magnitudes
  logic          rneg_r;
  logic [DW-1:0] gx_r, gy_r;          // Euclid pair
  logic [DW-1:0] qn_r;
  logic [1:0]    st_r;
  logic          lt_r, eq_r, gt_r;
  rau_out_t      out_r;

  // sign-magnitude of one operand field at VALUE_WIDTH
  function automatic logic [32:0] smag(input logic [31:0] raw);
    logic [31:0] v;
    logic        s;
    begin
      v = raw;
      if (VALUE_WIDTH < 32) v = 32'(signed'(raw << (32 - VALUE_WIDTH)) >>> (32 - VALUE_WIDTH));
      s = v[31];
      smag = {s, s ? (32'd0 - v) : v};
    end
  endfunction

  logic [32:0] san, sad, sbn, sbd;
  assign san = smag(in_data.a_num);
  assign sad = smag(in_data.a_den);
  assign sbn = smag(in_data.b_num);
  assign sbd = smag(in_data.b_den);

  // shared multiplier, one product per cycle
  logic [31:0] mx, my;
  logic [DW-1:0] prod;
  always_comb begin
    case (mi_r)
      2'd0:    begin mx = an_r; my = bd_r; end
      2'd1:    begin mx = bn_r; my = ad_r; end
      2'd2:    begin mx = an_r; my = bn_r; end
      default: begin mx = ad_r; my = bd_r; end
    endcase
  end
  assign prod = DW'(mx) * DW'(my);

  // shared divider
  rau_div_ctl_t dctl;
  rau_div_sts_t dsts;
  logic [DW-1:0] d_a, d_b, d_q, d_r;

  rau_div #(.W(DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (dctl),
    .dividend  (d_a),
    .divisor   (d_b),
    .sts       (dsts),
    .quotient  (d_q),
    .remainder (d_r)
  );

  // form step: signed sum / product choice
  logic sl, sr, pn, qs;
  logic [DW-1:0] sum_m;
  logic          sum_n;
  always_comb begin
    pn = ans_r ^ bds_r;
    qs = (bns_r ^ ads_r) ^ (act_r == ACT_SUB);
    if (pn == qs) begin
      sum_m = p0_r + p1_r;
      sum_n = pn;
    end else if (p0_r >= p1_r) begin
      sum_m = p0_r - p1_r;
      sum_n = pn;
    end else begin
      sum_m = p1_r - p0_r;
      sum_n = qs;
    end
    sl = ans_r ^ ads_r;
    sr = bns_r ^ bds_r;
  end

  // compare of cross products
  logic xn, yn, c_lt, c_eq;
  always_comb begin
    xn = sl && (p0_r != '0);
    yn = sr && (p1_r != '0);
    c_eq = (xn == yn) && (p0_r == p1_r);
    if (xn != yn) c_lt = xn;
    else          c_lt = xn ? (p0_r > p1_r) : (p0_r < p1_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MUL;
      S_MUL:  if (mi_r == 2'd3) state_nxt = S_FORM;
      S_FORM: state_nxt = S_GCD;
      S_GCD: begin
        if (st_r != ST_OK) state_nxt = S_FIN;
        else if (gy_r == '0 && gx_r != '0 && !dsts.busy && !dsts.done)
          state_nxt = S_DIVN;
      end
      S_DIVN: if (dsts.done) state_nxt = S_DIVD;
      S_DIVD: if (dsts.done) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // divider control and operands
  always_comb begin
    dctl.start = 1'b0;
    d_a = gx_r;
    d_b = gy_r;
    unique case (state_r)
      S_GCD: dctl.start = (st_r == ST_OK) && (gy_r != '0) && !dsts.busy && !dsts.done;
      S_DIVN: begin
        d_a = nm_r;
        d_b = gx_r;
        dctl.start = !dsts.busy && !dsts.done;
      end
      S_DIVD: begin
        d_a = dm_r;
        d_b = gx_r;
        dctl.start = !dsts.busy && !dsts.done;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mi_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      mi_r    <= (state_r == S_MUL) ? mi_r + 2'd1 : 2'd0;
    end
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        {ans_r, an_r} <= san;
        {ads_r, ad_r} <= sad;
        {bns_r, bn_r} <= sbn;
        {bds_r, bd_r} <= sbd;
        act_r <= in_data.action;
      end
      S_MUL: begin
        case (mi_r)
          2'd0:    p0_r <= prod;
          2'd1:    p1_r <= prod;
          2'd2:    p2_r <= prod;
          default: p3_r <= prod;
        endcase
      end
      S_FORM: begin
        if (ad_r != '0 && bd_r != '0) begin
          lt_r <= c_lt;
          eq_r <= c_eq;
          gt_r <= !c_lt && !c_eq;
        end else begin
          lt_r <= 1'b0;
          eq_r <= 1'b0;
          gt_r <= 1'b0;
        end
        st_r   <= ST_OK;
        nm_r   <= '0;
        dm_r   <= DW'(1);
        rneg_r <= 1'b0;
        if (ad_r == '0 || (!act_r[2] && bd_r == '0)) begin
          st_r <= ST_DIV0;
        end else if (act_r[2]) begin
          nm_r   <= DW'(an_r);
          dm_r   <= DW'(ad_r);
          rneg_r <= (an_r != '0) && (ans_r == ads_r);
        end else if (act_r == ACT_ADD || act_r == ACT_SUB) begin
          nm_r   <= sum_m;
          dm_r   <= p3_r;
          rneg_r <= (sum_m != '0) && (sum_n != (ads_r ^ bds_r));
        end else if (act_r == ACT_MUL) begin
          nm_r   <= p2_r;
          dm_r   <= p3_r;
          rneg_r <= (p2_r != '0) && ((ans_r ^ bns_r) != (ads_r ^ bds_r));
        end else begin
          nm_r   <= p0_r;
          dm_r   <= p1_r;
          rneg_r <= (p0_r != '0) && ((ans_r ^ bds_r) != (ads_r ^ bns_r));
          if (bn_r == '0) st_r <= ST_DIV0;
        end
        gx_r <= '0;
        gy_r <= '0;
      end
      S_GCD: begin
        if (gx_r == '0 && gy_r == '0) begin
          gx_r <= nm_r;
          gy_r <= dm_r;
        end else if (dsts.done) begin
          gx_r <= gy_r;
          gy_r <= d_r;
        end
      end
      S_DIVN: if (dsts.done) qn_r <= d_q;
      S_DIVD: if (dsts.done) dm_r <= (qn_r == '0) ? DW'(1) : d_q;
      S_FIN: begin
        out_r.a_less    <= lt_r;
        out_r.a_equal   <= eq_r;
        out_r.a_greater <= gt_r;
        out_r.res_num   <= '0;
        out_r.res_den   <= '0;
        out_r.status    <= st_r;
        if (st_r == ST_OK) begin
          if (dm_r > LIM - DW'(1) || (rneg_r ? qn_r > LIM : qn_r > LIM - DW'(1))) begin
            out_r.status <= ST_OVF;
          end else begin
            out_r.res_num <= rneg_r ? (32'd0 - qn_r[31:0]) : qn_r[31:0];
            out_r.res_den <= dm_r[30:0];
          end
        end
      end
      default: ;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
  end
  assign out_data = out_r;

`ifndef SYNTH
  // never both sides open at once
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("in and out open together");
  // an accepted word starts the multiply sequence
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_MUL) else $error("accept lost");
  // exactly one compare flag or none
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_data.a_less, out_data.a_equal, out_data.a_greater}))
    else $error("compare flags conflict");
  // error results carry zero fraction
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.res_den == '0))
    else $error("error result with denominator");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for rational_arithmetic_unit
// Drives fraction words with random idling, predicts each reduced result
// and compare flags in SystemVerilog, and checks every output word in order.
// ----------------------------------------------------------------------------
module tb_top
  import rau_pkg::*;
();

  localparam int unsigned VW = 32;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  rau_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  rau_out_t out_data;

  rau_in_t  pending_words[$];
  rau_out_t expected_results[$];
  int       errors;
  bit       stim_done;
  bit       hold_send;
  bit       quiet;
  bit       in_acc;

  rational_arithmetic_unit #(.VALUE_WIDTH(VW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // sign-magnitude split of one operand at VW bits
  function automatic void split_val(input logic [31:0] raw, output bit neg,
                                    output logic [63:0] mag);
    logic [63:0] v;
    v = {32'd0, raw} & ((64'd1 << VW) - 64'd1);
    neg = v[VW-1];
    mag = neg ? ((64'd1 << VW) - v) : v;
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // expected result word for one fraction operation
  function automatic rau_out_t reduce_fraction(input rau_in_t w);
    rau_out_t r;
    bit an_s, ad_s, bn_s, bd_s, ln, rn, nn, dn, rneg, neg_act, div0;
    logic [63:0] an, ad, bn, bd, lm, rm, nm, dm, p, q, g, lim;
    r = '0;
    split_val(w.a_num, an_s, an);
    split_val(w.a_den, ad_s, ad);
    split_val(w.b_num, bn_s, bn);
    split_val(w.b_den, bd_s, bd);
    neg_act = w.action[2];
    // compare by cross products
    if (ad != 0 && bd != 0) begin
      lm = an * bd;
      ln = (an_s != ad_s) && lm != 0;
      rm = bn * ad;
      rn = (bn_s != bd_s) && rm != 0;
      if (ln != rn) begin
        r.a_less = ln;
        r.a_greater = rn;
      end else if (lm == rm) begin
        r.a_equal = 1'b1;
      end else begin
        r.a_less = (lm < rm) ^ ln;
        r.a_greater = !((lm < rm) ^ ln);
      end
    end
    div0 = (ad == 0) || (!neg_act && bd == 0);
    nn = 0; nm = 0; dn = 0; dm = 1;
    if (!div0) begin
      if (neg_act) begin
        nm = an; nn = !an_s; dm = ad; dn = ad_s;
      end else if (w.action == ACT_ADD || w.action == ACT_SUB) begin
        p = an * bd;
        q = ad * bn;
        ln = (an_s != bd_s);
        rn = (ad_s != bn_s) ^ (w.action == ACT_SUB);
        if (ln == rn) begin
          nm = p + q; nn = ln;
        end else if (p >= q) begin
          nm = p - q; nn = ln;
        end else begin
          nm = q - p; nn = rn;
        end
        dm = ad * bd; dn = ad_s != bd_s;
      end else if (w.action == ACT_MUL) begin
        nm = an * bn; nn = an_s != bn_s;
        dm = ad * bd; dn = ad_s != bd_s;
      end else begin
        nm = an * bd; nn = an_s != bd_s;
        dm = ad * bn; dn = ad_s != bn_s;
        if (dm == 0) div0 = 1;
      end
    end
    if (div0) begin
      r.status = ST_DIV0;
      return r;
    end
    rneg = nm != 0 && (nn != dn);
    g = gcd64(nm, dm);
    nm = nm / g;
    dm = dm / g;
    if (nm == 0) dm = 1;
    lim = 64'd1 << (VW - 1);
    if (dm > lim - 1 || (rneg ? nm > lim : nm > lim - 1)) begin
      r.status = ST_OVF;
    end else begin
      r.status = ST_OK;
      r.res_num = rneg ? (32'd0 - nm[31:0]) : nm[31:0];
      r.res_den = dm[30:0];
    end
    return r;
  endfunction

  function automatic rau_in_t mk(input logic [2:0] act, input logic [31:0] an,
                                 input logic [31:0] ad, input logic [31:0] bn,
                                 input logic [31:0] bd);
    rau_in_t w;
    w.action = act; w.a_num = an; w.a_den = ad; w.b_num = bn; w.b_den = bd;
    return w;
  endfunction

  // operand mix: mostly small, some full-width
  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 3) == 0 ? 32'd0 : 32'h8000_0000;
      3:       return 32'sd0 - $urandom_range(1, 1000);
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  // driver: present words at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_acc) begin
      // accepted at the last rising edge; computed there by the monitor
      if (pending_words.size() > 0 && !hold_send
          && (quiet || $urandom_range(0, 99) >= 10)) begin
        in_data <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && pending_words.size() > 0 && !hold_send
                 && (quiet || $urandom_range(0, 99) >= 10)) begin
      in_data  <= pending_words.pop_front();
      in_valid <= 1'b1;
    end
    out_ready <= quiet || ($urandom_range(0, 99) >= 10);
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    rau_out_t e;
    in_acc = rst_n && in_valid && in_ready;
    if (in_acc)
      expected_results.push_back(reduce_fraction(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word %h", out_data);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.res_num !== e.res_num) begin
          $error("res_num exp %h got %h", e.res_num, out_data.res_num); errors++;
        end
        if (out_data.res_den !== e.res_den) begin
          $error("res_den exp %h got %h", e.res_den, out_data.res_den); errors++;
        end
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status); errors++;
        end
        if (out_data.a_less !== e.a_less) begin
          $error("a_less exp %b got %b", e.a_less, out_data.a_less); errors++;
        end
        if (out_data.a_equal !== e.a_equal) begin
          $error("a_equal exp %b got %b", e.a_equal, out_data.a_equal); errors++;
        end
        if (out_data.a_greater !== e.a_greater) begin
          $error("a_greater exp %b got %b", e.a_greater, out_data.a_greater); errors++;
        end
      end
    end
  end

  // stimulus and end of test
  initial begin
    int k;
    errors = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    hold_send = 1'b0;
    quiet = 1'b0;
    // directed: every action, extremes, zero denominators, sign cases
    pending_words.push_back(mk(ACT_ADD, 1, 2, 1, 3));
    pending_words.push_back(mk(ACT_SUB, 1, 2, 1, 2));
    pending_words.push_back(mk(ACT_MUL, -3, -4, 2, 9));
    pending_words.push_back(mk(ACT_DIV, 5, 7, -10, 21));
    pending_words.push_back(mk(ACT_NEG, -6, -4, 0, 0));
    pending_words.push_back(mk(3'd5, 32'h8000_0000, 1, 1, 1));
    pending_words.push_back(mk(3'd6, 32'h7fff_ffff, -1, 2, 3));
    pending_words.push_back(mk(3'd7, 0, 5, 1, 0));
    pending_words.push_back(mk(ACT_ADD, 1, 0, 1, 1));
    pending_words.push_back(mk(ACT_MUL, 1, 1, 1, 0));
    pending_words.push_back(mk(ACT_DIV, 1, 2, 0, 3));
    pending_words.push_back(mk(ACT_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1));
    pending_words.push_back(mk(ACT_SUB, 32'h8000_0000, 1, 1, 1));
    pending_words.push_back(mk(ACT_MUL, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000));
    pending_words.push_back(mk(ACT_DIV, 32'hffff_ffff, 32'hffff_ffff,
                               32'h7fff_ffff, 32'h8000_0000));
    pending_words.push_back(mk(ACT_MUL, 0, -7, 5, 3));
    pending_words.push_back(mk(ACT_NEG, 32'h8000_0000, 1, 0, 1));
    pending_words.push_back(mk(ACT_NEG, 32'h8000_0000, -1, 0, 1));
    pending_words.push_back(mk(ACT_ADD, 2, 4, 3, 6));
    pending_words.push_back(mk(ACT_DIV, 1, 32'h7fff_ffff, 32'h7fff_ffff, 1));
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // random words
    for (k = 0; k < 550; k++) begin
      logic [31:0] ad, bd;
      ad = rand_val();
      bd = rand_val();
      if (ad == 0 && $urandom_range(0, 3) != 0) ad = 1;
      if (bd == 0 && $urandom_range(0, 3) != 0) bd = 3;
      pending_words.push_back(mk($urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
                                 : 3'($urandom_range(0, 4)),
                                 rand_val(), ad, rand_val(), bd));
      if (k == 200) begin
        // drain fully once, then a stretch with no idling
        wait (pending_words.size() == 0 && !in_valid);
        hold_send = 1'b1;
        wait (expected_results.size() == 0);
        @(negedge clk);
        hold_send = 1'b0;
        quiet = 1'b1;
      end
      if (k == 320) begin
        // quiet stretch covers the words queued since the drain
        wait (pending_words.size() == 0);
        quiet = 1'b0;
      end
    end
    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("rational_arithmetic_unit: match");
    end else begin
      $display("rational_arithmetic_unit: mismatch");
    end
    $finish;
  end

  // watchdog: ~570 words at a 12 ns clock; a hung run ends as a mismatch
  initial begin
    #300_000_000;
    $display("rational_arithmetic_unit: mismatch");
    $finish;
  end

endmodule
